@@ rtl/holt_forecast_worker_scaler_unit_defines.svh @@
// Assertion macros for the Holt forecast worker scaler.
`ifndef HOLT_FORECAST_WORKER_SCALER_UNIT_DEFINES_SVH
`define HOLT_FORECAST_WORKER_SCALER_UNIT_DEFINES_SVH

// same-cycle implication
`define HFWS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hfws check failed");

// next-cycle implication
`define HFWS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hfws check failed");

`endif

@@ rtl/hfws_pkg.sv @@
// Package: types, constants, microcode table and helpers of the worker scaler.
package hfws_pkg;

   localparam int THREAD_LIMIT = 64;
   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] CAP_LIMIT =
      (THREAD_LIMIT > 127) ? 7'd127 : CNT_W'(THREAD_LIMIT);
   localparam int CSR_W = 31;
   localparam logic [16:0] GAIN_ONE = 17'd65536;
   localparam logic signed [39:0] S32_MAX_X = 40'sh00_7FFF_FFFF;
   localparam logic signed [39:0] S32_MIN_X = 40'shFF_8000_0000;

   typedef enum logic [1:0] {
      KIND_OBS      = 2'd0,
      KIND_PREEMPT  = 2'd1,
      KIND_EXIT     = 2'd2,
      KIND_DISPATCH = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_MAX_THREADS = 2'd0,
      CSR_MAX_PENALTY = 2'd1,
      CSR_LEVEL_GAIN  = 2'd2,
      CSR_TREND_GAIN  = 2'd3
   } csr_idx_type;

   localparam logic [1:0] RATE_STARVED = 2'b11;
   localparam logic [1:0] RATE_SURPLUS = 2'b01;

   typedef struct packed {
      logic [6:0]  max_threads;
      logic [30:0] max_penalty;
      logic [16:0] level_gain;
      logic [16:0] trend_gain;
   } cfg_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_YT,
      UOP_PTREND,
      UOP_DIFF_L,
      UOP_MUL_L,
      UOP_WR_L,
      UOP_DIFF_T,
      UOP_MUL_T,
      UOP_WR_T,
      UOP_SEED,
      UOP_FCAST,
      UOP_DECIDE,
      UOP_PREEMPT,
      UOP_EXIT,
      UOP_DISPATCH,
      UOP_PUBLISH
   } uop_type;

   typedef enum logic [1:0] {
      JC_NONE,
      JC_ALWAYS,
      JC_SEED
   } jcond_type;

   typedef logic [3:0] upc_type;

   localparam upc_type PC_YT       = 4'd0;
   localparam upc_type PC_PTREND   = 4'd1;
   localparam upc_type PC_DIFF_L   = 4'd2;
   localparam upc_type PC_MUL_L    = 4'd3;
   localparam upc_type PC_WR_L     = 4'd4;
   localparam upc_type PC_DIFF_T   = 4'd5;
   localparam upc_type PC_MUL_T    = 4'd6;
   localparam upc_type PC_WR_T     = 4'd7;
   localparam upc_type PC_FCAST    = 4'd8;
   localparam upc_type PC_DECIDE   = 4'd9;
   localparam upc_type PC_SEED     = 4'd10;
   localparam upc_type PC_PREEMPT  = 4'd11;
   localparam upc_type PC_EXIT     = 4'd12;
   localparam upc_type PC_DISPATCH = 4'd13;
   localparam upc_type PC_PUBLISH  = 4'd14;

   typedef struct packed {
      uop_type   op;
      jcond_type cond;
      upc_type   target;
      logic      last;
   } uword_type;

   typedef struct packed {
      logic    en;
      uop_type op;
   } ctrl_type;

   typedef struct packed {
      logic        dispatched;
      logic        granted;
      logic [6:0]  active;
      logic [31:0] fcast;
   } rslt_type;

   function automatic uword_type ucode(input upc_type pc);
      uword_type w;
      w = '{op: UOP_NOP, cond: JC_NONE, target: PC_PUBLISH, last: 1'b1};
      unique case (pc)
         PC_YT:       w = '{UOP_YT,       JC_SEED,   PC_SEED,    1'b0};
         PC_PTREND:   w = '{UOP_PTREND,   JC_NONE,   PC_PUBLISH, 1'b0};
         PC_DIFF_L:   w = '{UOP_DIFF_L,   JC_NONE,   PC_PUBLISH, 1'b0};
         PC_MUL_L:    w = '{UOP_MUL_L,    JC_NONE,   PC_PUBLISH, 1'b0};
         PC_WR_L:     w = '{UOP_WR_L,     JC_NONE,   PC_PUBLISH, 1'b0};
         PC_DIFF_T:   w = '{UOP_DIFF_T,   JC_NONE,   PC_PUBLISH, 1'b0};
         PC_MUL_T:    w = '{UOP_MUL_T,    JC_NONE,   PC_PUBLISH, 1'b0};
         PC_WR_T:     w = '{UOP_WR_T,     JC_NONE,   PC_PUBLISH, 1'b0};
         PC_FCAST:    w = '{UOP_FCAST,    JC_NONE,   PC_PUBLISH, 1'b0};
         PC_DECIDE:   w = '{UOP_DECIDE,   JC_ALWAYS, PC_PUBLISH, 1'b0};
         PC_SEED:     w = '{UOP_SEED,     JC_ALWAYS, PC_FCAST,   1'b0};
         PC_PREEMPT:  w = '{UOP_PREEMPT,  JC_ALWAYS, PC_PUBLISH, 1'b0};
         PC_EXIT:     w = '{UOP_EXIT,     JC_ALWAYS, PC_PUBLISH, 1'b0};
         PC_DISPATCH: w = '{UOP_DISPATCH, JC_ALWAYS, PC_PUBLISH, 1'b0};
         PC_PUBLISH:  w = '{UOP_PUBLISH,  JC_NONE,   PC_PUBLISH, 1'b1};
         default:     w = '{UOP_NOP,      JC_NONE,   PC_PUBLISH, 1'b1};
      endcase
      return w;
   endfunction

   function automatic upc_type entry_pc(input kind_type k);
      upc_type pc;
      pc = PC_YT;
      unique case (k)
         KIND_OBS:      pc = PC_YT;
         KIND_PREEMPT:  pc = PC_PREEMPT;
         KIND_EXIT:     pc = PC_EXIT;
         KIND_DISPATCH: pc = PC_DISPATCH;
         default:       pc = PC_YT;
      endcase
      return pc;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > S32_MAX_X) begin
         r = 32'h7FFF_FFFF;
      end else if (v < S32_MIN_X) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [16:0] gain_clamp(input logic [16:0] g);
      return (g > GAIN_ONE) ? GAIN_ONE : g;
   endfunction

endpackage

@@ rtl/hfws_req_if.sv @@
// Request channel interface: valid/ready handshake with the item payload.
interface hfws_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic signed [31:0] wait_delta;
   logic signed [1:0]  rate_trend;

   modport source (output valid, kind, wait_delta, rate_trend, input ready);
   modport sink   (input valid, kind, wait_delta, rate_trend, output ready);
endinterface

@@ rtl/hfws_rsp_if.sv @@
// Response channel interface: valid/ready handshake with the result payload.
interface hfws_rsp_if;
   logic              valid;
   logic              ready;
   logic              dispatched;
   logic              preempt_granted;
   logic [6:0]        active_threads;
   logic signed [31:0] forecast;

   modport source (output valid, dispatched, preempt_granted, active_threads, forecast,
                   input ready);
   modport sink   (input valid, dispatched, preempt_granted, active_threads, forecast,
                   output ready);
endinterface

@@ rtl/hfws_useq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module hfws_useq
   import hfws_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  upc_type   start_pc,
   input  logic      adv,
   input  logic      seed,
   output logic      busy,
   output uword_type uw
);

   upc_type pc_ff, pc_in;
   logic    busy_ff, busy_in;
   logic    jump;

   assign uw   = ucode(pc_ff);
   assign busy = busy_ff;
   assign jump = (uw.cond == JC_ALWAYS) || ((uw.cond == JC_SEED) && seed);

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = start_pc;
         busy_in = 1'b1;
      end else if (adv) begin
         if (uw.last) begin
            busy_in = 1'b0;
         end else if (jump) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_YT;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

@@ rtl/hfws_core.sv @@
// Datapath: Holt level/trend update on a shared multiplier, accumulator and thread control.
module hfws_core
   import hfws_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  ctrl_type           ctrl,
   input  logic signed [31:0] delta,
   input  logic [1:0]         rate,
   output logic               seed,
   output rslt_type           rslt
);

   // model state
   logic [1:0]         sc_ff, sc_in;
   logic signed [31:0] level_ff, level_in;
   logic signed [31:0] trend_ff, trend_in;
   logic signed [31:0] last_obs_ff, last_obs_in;
   logic signed [31:0] fcast_ff, fcast_in;
   logic signed [31:0] acc_ff, acc_in;
   logic               stop_ff, stop_in;
   logic [6:0]         tc_ff, tc_in;
   logic               disp_ff, disp_in;
   logic               grant_ff, grant_in;
   // working registers
   logic signed [31:0] yt_ff, yt_in;
   logic signed [31:0] prev_level_ff, prev_level_in;
   logic signed [32:0] ptrend_ff, ptrend_in;
   logic signed [33:0] base_ff, base_in;
   logic signed [34:0] diff_ff, diff_in;
   logic signed [52:0] prod_ff, prod_in;

   logic signed [17:0] gain_op;
   logic signed [53:0] blend_sum;
   logic signed [37:0] blend_q;
   logic [31:0]        blend_res;
   logic signed [33:0] lvl_base;
   logic signed [32:0] ptrend_calc;
   logic signed [37:0] yt20;
   logic [6:0]         cap;
   logic               can_start;
   logic               early, pen_hit, slow_hit, request;

   assign seed = (sc_ff == 2'd0);

   assign gain_op = $signed({1'b0, (ctrl.op == UOP_MUL_T) ? gain_clamp(cfg.trend_gain)
                                                           : gain_clamp(cfg.level_gain)});
   assign prod_in = diff_ff * gain_op;

   // g*(x-y) + y*2^16 + half, floor by 2^16
   assign blend_sum = 54'(prod_ff) + $signed({base_ff, 16'b0}) + 54'sd32768;
   assign blend_q   = blend_sum[53:16];
   assign blend_res = sat32(40'(blend_q));

   assign ptrend_calc = (sc_ff == 2'd2) ? (33'(yt_ff) - 33'(last_obs_ff)) : 33'(trend_ff);
   assign lvl_base    = 34'(level_ff) + 34'(ptrend_ff);

   assign cap       = (cfg.max_threads > CAP_LIMIT) ? CAP_LIMIT : cfg.max_threads;
   assign can_start = (tc_ff < cap);

   assign yt20     = (38'(yt_ff) <<< 4) + (38'(yt_ff) <<< 2) + 38'sd19;
   assign early    = (sc_ff == 2'd1);
   assign pen_hit  = (34'(acc_ff) + 34'(fcast_ff)) >= $signed({3'b0, cfg.max_penalty});
   // yt >= penalty/20 written as 20*yt + 19 >= penalty
   assign slow_hit = (yt20 >= $signed({7'b0, cfg.max_penalty}))
                     && (34'(acc_ff) >= $signed({2'b0, cfg.max_penalty, 1'b0}));

   always_comb begin
      request = 1'b0;
      if (early) begin
         request = pen_hit;
      end else if (rate == RATE_STARVED) begin
         request = (tc_ff == 7'd0) || slow_hit;
      end
   end

   always_comb begin
      sc_in         = sc_ff;
      level_in      = level_ff;
      trend_in      = trend_ff;
      last_obs_in   = last_obs_ff;
      fcast_in      = fcast_ff;
      acc_in        = acc_ff;
      stop_in       = stop_ff;
      tc_in         = tc_ff;
      disp_in       = disp_ff;
      grant_in      = grant_ff;
      yt_in         = yt_ff;
      prev_level_in = prev_level_ff;
      ptrend_in     = ptrend_ff;
      base_in       = base_ff;
      diff_in       = diff_ff;
      if (ctrl.en) begin
         unique case (ctrl.op)
            UOP_YT: begin
               yt_in = sat32(40'(delta) + 40'(last_obs_ff));
               sc_in = (sc_ff == 2'd3) ? 2'd3 : sc_ff + 2'd1;
            end
            UOP_PTREND: ptrend_in = ptrend_calc;
            UOP_DIFF_L: begin
               base_in = lvl_base;
               diff_in = 35'(yt_ff) - 35'(lvl_base);
            end
            UOP_WR_L: begin
               prev_level_in = level_ff;
               level_in      = blend_res;
            end
            UOP_DIFF_T: begin
               base_in = 34'(ptrend_ff);
               diff_in = 35'(level_ff) - 35'(prev_level_ff) - 35'(ptrend_ff);
            end
            UOP_WR_T: trend_in = blend_res;
            UOP_SEED: level_in = yt_ff;
            UOP_FCAST: begin
               fcast_in = sat32(40'(level_ff) + 40'(trend_ff));
               acc_in   = sat32(40'(acc_ff) + 40'(yt_ff));
            end
            UOP_DECIDE: begin
               last_obs_in = yt_ff;
               grant_in    = 1'b0;
               disp_in     = 1'b0;
               if (!early && rate == RATE_SURPLUS && tc_ff > 7'd1) begin
                  stop_in = 1'b1;
               end
               if (request) begin
                  stop_in = 1'b0;
                  acc_in  = '0;
                  if (can_start) begin
                     tc_in   = tc_ff + 7'd1;
                     disp_in = 1'b1;
                  end
               end
            end
            UOP_PREEMPT: begin
               disp_in  = 1'b0;
               grant_in = 1'b0;
               if (tc_ff > 7'd1 && stop_ff) begin
                  stop_in  = 1'b0;
                  tc_in    = tc_ff - 7'd1;
                  grant_in = 1'b1;
               end
            end
            UOP_EXIT: begin
               disp_in  = 1'b0;
               grant_in = 1'b0;
               stop_in  = 1'b0;
               if (tc_ff != 7'd0) begin
                  tc_in = tc_ff - 7'd1;
               end
            end
            UOP_DISPATCH: begin
               grant_in = 1'b0;
               disp_in  = can_start;
               if (can_start) begin
                  tc_in = tc_ff + 7'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff       <= '0;
         level_ff    <= '0;
         trend_ff    <= '0;
         last_obs_ff <= '0;
         fcast_ff    <= '0;
         acc_ff      <= '0;
         stop_ff     <= 1'b0;
         tc_ff       <= '0;
      end else begin
         sc_ff       <= sc_in;
         level_ff    <= level_in;
         trend_ff    <= trend_in;
         last_obs_ff <= last_obs_in;
         fcast_ff    <= fcast_in;
         acc_ff      <= acc_in;
         stop_ff     <= stop_in;
         tc_ff       <= tc_in;
      end
   end

   always_ff @(posedge clock) begin
      disp_ff       <= disp_in;
      grant_ff      <= grant_in;
      yt_ff         <= yt_in;
      prev_level_ff <= prev_level_in;
      ptrend_ff     <= ptrend_in;
      base_ff       <= base_in;
      diff_ff       <= diff_in;
      if (ctrl.en && (ctrl.op == UOP_MUL_L || ctrl.op == UOP_MUL_T)) begin
         prod_ff <= prod_in;
      end
   end

   assign rslt = '{dispatched: disp_ff, granted: grant_ff, active: tc_ff, fcast: fcast_ff};

endmodule

@@ rtl/holt_forecast_worker_scaler_unit.sv @@
// Top level of the Holt forecast worker scaler: handshakes, registers, sequencer and datapath.
//
// Usage: items enter on req_ch (kind, wait_delta, rate_trend) under valid/ready; each
// item gives exactly one result on rsp_ch (dispatched, preempt_granted, active_threads,
// forecast). Settings are written on csr_we/csr_index/csr_wdata while no item is in flight.
// Items are worked one at a time by a microcoded sequencer over one shared 35x18
// multiplier; each microprogram ends in a publish step that registers the result:
//   observation after the first: wait, prior trend, level and trend blends, forecast, decision
//   first observation (level seeding): wait, level seed, forecast, decision
//   preempt check, thread exit, dispatch request: the action step alone
// No new item is taken until the result of the current one is registered. The result
// sits in an output register; if the receiver stalls, it holds there and the following
// item runs up to its last step and then waits until the held result is taken.
// Reset (synchronous, active high) clears the forecast state, the accumulator and the
// thread count, and loads the settings with their defaults (4 threads, penalty 2.0,
// level gain 0.5, trend gain 0.8). No clearing pass is needed.
module holt_forecast_worker_scaler_unit
   import hfws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   hfws_req_if.sink          req_ch,
   hfws_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   cfg_type            cfg_ff, cfg_in;
   logic signed [31:0] delta_ff;
   logic [1:0]         rate_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rslt_type           rsp_data_ff;

   logic      busy, start, adv, seed;
   uword_type uw;
   ctrl_type  ctrl;
   rslt_type  rslt;

   assign req_ch.ready = !busy && !reset;
   assign start        = req_ch.valid && req_ch.ready;
   assign adv          = busy && (!uw.last || !rsp_valid_ff || rsp_ch.ready);
   assign ctrl         = '{en: adv, op: uw.op};

   hfws_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .start_pc (entry_pc(kind_type'(req_ch.kind))),
      .adv      (adv),
      .seed     (seed),
      .busy     (busy),
      .uw       (uw)
   );

   hfws_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .ctrl  (ctrl),
      .delta (delta_ff),
      .rate  (rate_ff),
      .seed  (seed),
      .rslt  (rslt)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAX_THREADS: cfg_in.max_threads = csr_wdata[6:0];
            CSR_MAX_PENALTY: cfg_in.max_penalty = csr_wdata;
            CSR_LEVEL_GAIN:  cfg_in.level_gain  = csr_wdata[16:0];
            CSR_TREND_GAIN:  cfg_in.trend_gain  = csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv && uw.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{max_threads: 7'd4, max_penalty: 31'd131072,
                           level_gain: 17'd32768, trend_gain: 17'd52429};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         delta_ff <= req_ch.wait_delta;
         rate_ff  <= req_ch.rate_trend;
      end
      if (adv && uw.last) begin
         rsp_data_ff <= rslt;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.dispatched      = rsp_data_ff.dispatched;
   assign rsp_ch.preempt_granted = rsp_data_ff.granted;
   assign rsp_ch.active_threads  = rsp_data_ff.active;
   assign rsp_ch.forecast        = rsp_data_ff.fcast;

endmodule

@@ rtl/hfws_checker.sv @@
// Port-level assertion checker for the worker scaler, bound to the top level.
`include "holt_forecast_worker_scaler_unit_defines.svh"

module hfws_checker
   import hfws_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       dispatched,
   input logic       granted,
   input logic [6:0] active_threads
);

   `HFWS_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready && !reset, !req_ready)
   `HFWS_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready && !reset, rsp_valid)
   `HFWS_ASSERT_IMP(a_one_action, clock, reset, rsp_valid, !(dispatched && granted))
   `HFWS_ASSERT_IMP(a_thread_cap, clock, reset, rsp_valid, active_threads <= CAP_LIMIT)

endmodule

bind holt_forecast_worker_scaler_unit hfws_checker u_hfws_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .dispatched     (rsp_ch.dispatched),
   .granted        (rsp_ch.preempt_granted),
   .active_threads (rsp_ch.active_threads)
);

@@ test/testbench.sv @@
// Self-checking testbench for the Holt forecast worker scaler unit.
`timescale 1ns / 1ps

module testbench
   import hfws_pkg::*;
();

   localparam longint S32_TOP    = 64'sd2147483647;
   localparam longint S32_BOTTOM = -64'sd2147483648;
   localparam int     SETTLE_CYCLES = 16;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   hfws_req_if req_ch();
   hfws_rsp_if rsp_ch();

   holt_forecast_worker_scaler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow registers and forecast state
   cfg_type csr_shadow;
   logic [1:0] obs_steps;
   logic signed [31:0] model_level;
   logic signed [31:0] model_trend;
   logic signed [31:0] prev_wait;
   logic signed [31:0] held_forecast;
   logic signed [31:0] wait_total;
   logic spare_stop;
   logic [6:0] workers;

   rslt_type pending_outcomes[$];
   rslt_type want;
   int send_idle_pct;
   int recv_stall_pct;
   int items_sent;
   int results_seen;
   int dispatch_seen;
   int grant_seen;
   int mismatches;
   int settings_used;

   always #5 clock = ~clock;

   function automatic logic signed [31:0] clip_s32(input longint v);
      if (v > S32_TOP) return 32'sh7FFF_FFFF;
      if (v < S32_BOTTOM) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] mix_q16(input logic [16:0] g, input longint x,
                                                  input longint y);
      longint gi;
      longint acc;
      gi = (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
      acc = gi * x + (64'sd65536 - gi) * y;
      return clip_s32((acc + 64'sd32768) >>> 16);
   endfunction

   function automatic logic start_worker();
      logic [6:0] cap;
      cap = (csr_shadow.max_threads > CAP_LIMIT) ? CAP_LIMIT : csr_shadow.max_threads;
      if (workers < cap) begin
         workers = workers + 7'd1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic take_observation(input logic signed [31:0] delta,
                                             input logic [1:0] rate);
      logic signed [31:0] yt;
      logic signed [31:0] old_level;
      longint old_trend;
      longint pen;
      logic want_worker;
      yt = clip_s32(longint'(delta) + longint'(prev_wait));
      pen = longint'(csr_shadow.max_penalty);
      want_worker = 1'b0;
      if (obs_steps < 2'd3) obs_steps = obs_steps + 2'd1;
      if (obs_steps == 2'd1) begin
         model_level = yt;
      end else begin
         old_level = model_level;
         old_trend = (obs_steps == 2'd2) ? longint'(yt) - longint'(prev_wait)
                                         : longint'(model_trend);
         model_level = mix_q16(csr_shadow.level_gain, longint'(yt),
                               longint'(old_level) + old_trend);
         model_trend = mix_q16(csr_shadow.trend_gain,
                               longint'(model_level) - longint'(old_level), old_trend);
      end
      held_forecast = clip_s32(longint'(model_level) + longint'(model_trend));
      wait_total = clip_s32(longint'(wait_total) + longint'(yt));
      if (obs_steps == 2'd1) begin
         if (longint'(wait_total) + longint'(held_forecast) >= pen) want_worker = 1'b1;
      end else if (rate == RATE_STARVED) begin
         if (workers < 7'd1) begin
            want_worker = 1'b1;
         end else if (longint'(yt) >= pen / 20 && longint'(wait_total) >= 2 * pen) begin
            want_worker = 1'b1;
         end
      end else if (rate == RATE_SURPLUS) begin
         if (workers > 7'd1) spare_stop = 1'b1;
      end
      if (want_worker) spare_stop = 1'b0;
      prev_wait = yt;
      if (want_worker) begin
         wait_total = '0;
         return start_worker();
      end
      return 1'b0;
   endfunction

   function automatic rslt_type forecast_and_schedule(input kind_type k,
                                                      input logic signed [31:0] delta,
                                                      input logic [1:0] rate);
      rslt_type r;
      r = '0;
      case (k)
         KIND_OBS: begin
            r.dispatched = take_observation(delta, rate);
         end
         KIND_PREEMPT: begin
            if (workers > 7'd1 && spare_stop) begin
               spare_stop = 1'b0;
               workers = workers - 7'd1;
               r.granted = 1'b1;
            end
         end
         KIND_EXIT: begin
            if (workers > 7'd0) workers = workers - 7'd1;
            spare_stop = 1'b0;
         end
         default: begin
            r.dispatched = start_worker();
         end
      endcase
      r.active = workers;
      r.fcast = held_forecast;
      return r;
   endfunction

   task automatic send_item(input kind_type k, input logic signed [31:0] d,
                            input logic [1:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.kind = k;
      req_ch.wait_delta = d;
      req_ch.rate_trend = r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_outcomes.insert(pending_outcomes.size(), forecast_and_schedule(k, d, r));
      items_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic drain_items();
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_MAX_THREADS: csr_shadow.max_threads = value[6:0];
         CSR_MAX_PENALTY: csr_shadow.max_penalty = value[30:0];
         CSR_LEVEL_GAIN:  csr_shadow.level_gain = value[16:0];
         default:         csr_shadow.trend_gain = value[16:0];
      endcase
   endtask

   task automatic write_all_csr(input logic [CSR_W-1:0] threads, input logic [CSR_W-1:0] pen,
                                input logic [CSR_W-1:0] lg, input logic [CSR_W-1:0] tg);
      drain_items();
      write_csr(CSR_MAX_THREADS, threads);
      write_csr(CSR_MAX_PENALTY, pen);
      write_csr(CSR_LEVEL_GAIN, lg);
      write_csr(CSR_TREND_GAIN, tg);
      settings_used++;
   endtask

   function automatic logic signed [31:0] pick_wait_delta();
      logic signed [31:0] d;
      case ($urandom_range(9))
         0: d = $urandom;
         1: begin
            case ($urandom_range(3))
               0: d = 32'sh7FFF_FFFF;
               1: d = 32'sh8000_0000;
               2: d = 32'sh0000_0000;
               default: d = 32'shFFFF_FFFF;
            endcase
         end
         default: d = $signed($urandom_range(524288)) - 32'sd262144;
      endcase
      return d;
   endfunction

   function automatic kind_type pick_kind();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return KIND_OBS;
      if (roll < 70) return KIND_PREEMPT;
      if (roll < 85) return KIND_EXIT;
      return KIND_DISPATCH;
   endfunction

   // seeding of level and trend, delta extremes, every rate hint, empty pool
   task automatic test_seeding_and_extremes();
      send_item(KIND_EXIT, 32'sd0, 2'b00);
      send_item(KIND_PREEMPT, 32'sd0, 2'b00);
      send_item(KIND_OBS, 32'sd98304, 2'b00);
      send_item(KIND_OBS, 32'sh7FFF_FFFF, RATE_STARVED);
      send_item(KIND_OBS, 32'sh8000_0000, RATE_SURPLUS);
      send_item(KIND_OBS, 32'sd0, 2'b10);
   endtask

   // worker limit, spare stop and preempt grant, exit clearing the stop
   task automatic test_thread_limits();
      repeat (5) send_item(KIND_DISPATCH, 32'sd0, 2'b00);
      send_item(KIND_OBS, 32'sd65536, RATE_SURPLUS);
      send_item(KIND_PREEMPT, 32'sd0, 2'b00);
      send_item(KIND_PREEMPT, 32'sd0, 2'b00);
      send_item(KIND_OBS, 32'sd65536, RATE_SURPLUS);
      send_item(KIND_EXIT, 32'sd0, 2'b00);
      send_item(KIND_PREEMPT, 32'sd0, 2'b00);
      write_all_csr(31'd0, 31'd131072, 31'd32768, 31'd52429);
      send_item(KIND_DISPATCH, 32'sd0, 2'b00);
      send_item(KIND_OBS, 32'sd655360, RATE_STARVED);
   endtask

   // gains at zero, one and above one, penalty at both ends
   task automatic test_gain_extremes();
      write_all_csr(31'd127, 31'd0, 31'd0, 31'd65536);
      send_item(KIND_OBS, 32'sd131072, RATE_STARVED);
      write_all_csr(31'd64, 31'h7FFF_FFFF, 31'd131071, 31'd131071);
      send_item(KIND_OBS, -32'sd65536, RATE_STARVED);
      send_item(KIND_OBS, 32'sd327680, 2'b00);
   endtask

   task automatic test_random_phases();
      int p;
      int n;
      for (p = 0; p < 8; p++) begin
         case (p)
            0: write_all_csr(31'd4, 31'd131072, 31'd32768, 31'd52429);
            1: write_all_csr(31'd64, 31'h7FFF_FFFF, 31'd65536, 31'd0);
            2: write_all_csr(CSR_W'($urandom_range(1, 8)), CSR_W'($urandom_range(1310720)),
                             CSR_W'($urandom_range(131071)),
                             CSR_W'($urandom_range(131071)));
            3: write_all_csr(31'd127, 31'd0, 31'd131071, 31'd131071);
            4: write_all_csr(31'd1, CSR_W'($urandom), CSR_W'($urandom_range(131071)),
                             CSR_W'($urandom_range(131071)));
            5: write_all_csr(CSR_W'($urandom_range(127)), CSR_W'($urandom),
                             CSR_W'($urandom_range(131071)),
                             CSR_W'($urandom_range(131071)));
            6: write_all_csr(31'd64, CSR_W'($urandom_range(1310720)), 31'd0, 31'd65536);
            default: write_all_csr(CSR_W'($urandom_range(1, 16)),
                                   CSR_W'($urandom_range(1310720)),
                                   CSR_W'($urandom_range(131071)),
                                   CSR_W'($urandom_range(131071)));
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         for (n = 0; n < 200; n++) begin
            send_item(pick_kind(), pick_wait_delta(), 2'($urandom_range(3)));
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: disp %0b grant %0b active %0d forecast %0h",
                        rsp_ch.dispatched, rsp_ch.preempt_granted,
                        rsp_ch.active_threads, rsp_ch.forecast);
            end
         end else begin
            want = pending_outcomes.pop_front();
            if (want.dispatched) dispatch_seen++;
            if (want.granted) grant_seen++;
            if (rsp_ch.dispatched !== want.dispatched ||
                rsp_ch.preempt_granted !== want.granted ||
                rsp_ch.active_threads !== want.active ||
                rsp_ch.forecast !== want.fcast) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d: disp %0b/%0b grant %0b/%0b active %0d/%0d fc %0h/%0h",
                           results_seen, want.dispatched, rsp_ch.dispatched,
                           want.granted, rsp_ch.preempt_granted, want.active,
                           rsp_ch.active_threads, want.fcast, rsp_ch.forecast);
               end
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results outstanding", pending_outcomes.size());
      $display("holt_forecast_worker_scaler_unit test failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_MAX_THREADS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_OBS;
      req_ch.wait_delta = '0;
      req_ch.rate_trend = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      items_sent = 0;
      results_seen = 0;
      dispatch_seen = 0;
      grant_seen = 0;
      mismatches = 0;
      settings_used = 1;
      csr_shadow = '{max_threads: 7'd4, max_penalty: 31'd131072,
                     level_gain: 17'd32768, trend_gain: 17'd52429};
      obs_steps = '0;
      model_level = '0;
      model_trend = '0;
      prev_wait = '0;
      held_forecast = '0;
      wait_total = '0;
      spare_stop = 1'b0;
      workers = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_seeding_and_extremes();
      test_thread_limits();
      test_gain_extremes();
      test_random_phases();

      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("%0d items sent, %0d results checked under %0d register settings",
               items_sent, results_seen, settings_used);
      $display("%0d workers started, %0d preempts granted, %0d mismatches",
               dispatch_seen, grant_seen, mismatches);
      if (mismatches == 0) begin
         $display("holt_forecast_worker_scaler_unit test passed");
      end else begin
         $display("holt_forecast_worker_scaler_unit test failed");
      end
      $finish;
   end

endmodule
